// ===== rtl/core/assert_macros.svh =====
// assertion macros for the rtl files, included by sha256_hash_top
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ON(lbl, prop) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
  !(cond)) else $error("forbidden condition seen");
`else
`define ASSERT_ON(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/core/sha256_pkg.sv =====
// sha-256 package: queue entry type, round constants, initial hash, round functions
// no dependencies
package sha256_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [31:0] PadWord = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] word;
    logic        is_final;
  } sha_word_t;

  typedef logic [7:0][31:0] hash_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ===== rtl/core/sha256_in_if.sv =====
// message word channel: valid/ready handshake plus one input word
// no dependencies
interface sha256_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        last_word;

  modport source(output valid, message_word, valid_bytes, last_word, input ready);
  modport sink(input valid, message_word, valid_bytes, last_word, output ready);
endinterface

// ===== rtl/core/sha256_out_if.sv =====
// digest word channel: valid/ready handshake plus one digest word
// no dependencies
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_digest;

  modport source(output valid, digest_word, word_index, last_digest, input ready);
  modport sink(input valid, digest_word, word_index, last_digest, output ready);
endinterface

// ===== rtl/core/sha256_fifo.sv =====
// small word queue between the padding front end and the compression core
// depends on sha256_pkg
module sha256_fifo import sha256_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sha_word_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output sha_word_t pop_data_o,
  output logic      empty_o
);

  sha_word_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;

  assign full_o     = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ===== rtl/core/sha256_front.sv =====
// front end: takes message words, counts length, inserts padding and length words
// depends on sha256_pkg and sha256_in_if
module sha256_front import sha256_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sha256_in_if.sink msg_i,
  output logic      push_o,
  output sha_word_t push_data_o,
  input  logic      full_i
);

  typedef enum logic [1:0] {ST_TAKE, ST_PADW, ST_ZERO, ST_LENLO} state_e;

  state_e      state_q;
  logic [3:0]  slot_q;
  logic [63:0] len_q;

  logic        accept;
  logic [2:0]  nbytes;
  logic [31:0] keep, pad, last_data;

  assign msg_i.ready = (state_q == ST_TAKE) && !full_i;
  assign accept      = msg_i.valid && msg_i.ready;
  assign nbytes      = (msg_i.valid_bytes > 3'd4) ? 3'd4 : msg_i.valid_bytes;

  // byte mask and pad marker for a short last word
  always_comb begin
    unique case (nbytes)
      3'd0:    begin keep = 32'h0000_0000; pad = 32'h8000_0000; end
      3'd1:    begin keep = 32'hff00_0000; pad = 32'h0080_0000; end
      3'd2:    begin keep = 32'hffff_0000; pad = 32'h0000_8000; end
      3'd3:    begin keep = 32'hffff_ff00; pad = 32'h0000_0080; end
      default: begin keep = 32'hffff_ffff; pad = 32'h0000_0000; end
    endcase
  end
  assign last_data = (msg_i.message_word & keep) | pad;

  // word pushed into the queue this cycle
  always_comb begin
    push_o      = 1'b0;
    push_data_o = '{word: '0, is_final: 1'b0};
    unique case (state_q)
      ST_TAKE: begin
        push_o           = accept;
        push_data_o.word = (msg_i.last_word && nbytes != 3'd4) ? last_data
                                                               : msg_i.message_word;
      end
      ST_PADW: begin
        push_o           = !full_i;
        push_data_o.word = PadWord;
      end
      ST_ZERO: begin
        push_o           = !full_i;
        push_data_o.word = (slot_q == 4'd14) ? len_q[63:32] : 32'h0;
      end
      ST_LENLO: begin
        push_o      = !full_i;
        push_data_o = '{word: len_q[31:0], is_final: 1'b1};
      end
      default: ;
    endcase
  end

  // sequencer, slot counter and bit length
  // the length low word always sits in slot 15, so the slot counter wraps to 0 there
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_TAKE;
      slot_q  <= '0;
      len_q   <= '0;
    end else begin
      if (push_o) slot_q <= slot_q + 1'b1;
      unique case (state_q)
        ST_TAKE: begin
          if (accept) begin
            if (!msg_i.last_word) begin
              len_q <= len_q + 64'd32;
            end else begin
              len_q   <= len_q + {58'd0, nbytes, 3'b000};
              state_q <= (nbytes == 3'd4) ? ST_PADW : ST_ZERO;
            end
          end
        end
        ST_PADW: begin
          if (!full_i) state_q <= ST_ZERO;
        end
        ST_ZERO: begin
          if (!full_i && slot_q == 4'd14) state_q <= ST_LENLO;
        end
        ST_LENLO: begin
          if (!full_i) begin
            state_q <= ST_TAKE;
            len_q   <= '0;
          end
        end
        default: state_q <= ST_TAKE;
      endcase
    end
  end

endmodule

// ===== rtl/core/sha256_back.sv =====
// compression core: loads 16-word blocks, runs 64 rounds, emits the digest
// depends on sha256_pkg and sha256_out_if
module sha256_back import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  output logic        pop_o,
  input  sha_word_t   pop_data_i,
  input  logic        empty_i,
  sha256_out_if.source dig_o
);

  typedef enum logic [1:0] {ST_LOAD, ST_ROUND, ST_ADD, ST_OUT} state_e;

  state_e      state_q;
  logic [5:0]  cnt_q;
  logic        fin_q;
  logic [2:0]  idx_q;
  hash_t       h_q;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic        ovalid_q, olast_q;
  logic [31:0] oword_q;
  logic [2:0]  oidx_q;

  logic        out_load;
  logic [31:0] t1, t2, w_new;

  assign pop_o    = (state_q == ST_LOAD) && !empty_i;
  assign out_load = (state_q == ST_OUT) && (!ovalid_q || dig_o.ready);

  // round datapath and schedule expansion
  assign t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + RoundK[cnt_q] + w_q[0];
  assign t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];

  // control and chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      fin_q    <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
    end else begin
      // output register: filled on a load, emptied when the sink takes it
      if (out_load) ovalid_q <= 1'b1;
      else if (dig_o.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        ST_LOAD: begin
          if (pop_o) begin
            if (cnt_q == 6'd15) begin
              fin_q   <= pop_data_i.is_final;
              cnt_q   <= '0;
              state_q <= ST_ROUND;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ST_ROUND: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd63) state_q <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          idx_q   <= '0;
          state_q <= fin_q ? ST_OUT : ST_LOAD;
        end
        ST_OUT: begin
          if (out_load) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
              state_q <= ST_LOAD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  // block buffer, working variables and output payload
  always_ff @(posedge clk_i) begin
    if (pop_o || state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= pop_o ? pop_data_i.word : w_new;
    end
    if (pop_o && cnt_q == 6'd15) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (state_q == ST_ROUND) begin
      for (int i = 7; i > 0; i--) v_q[i] <= v_q[i-1];
      v_q[4] <= v_q[3] + t1;
      v_q[0] <= t1 + t2;
    end
    if (out_load) begin
      oword_q <= h_q[idx_q];
      oidx_q  <= idx_q;
      olast_q <= (idx_q == 3'd7);
    end
  end

  assign dig_o.valid       = ovalid_q;
  assign dig_o.digest_word = oword_q;
  assign dig_o.word_index  = oidx_q;
  assign dig_o.last_digest = olast_q;

endmodule

// ===== rtl/core/sha256_hash_top.sv =====
// SHA-256 engine. Message words enter on msg_i (big-endian, last word may carry 0 to 4
// bytes); the front end appends FIPS padding and the 64-bit length, a four-entry queue
// holds block words, and the core loads 16 words then runs one round per cycle. A block
// is loaded from the queue, run through 64 rounds on the single shared round unit and
// added to the chaining value before the next block is loaded. The digest leaves as eight
// words on dig_o, one per cycle when taken; the front end may accept the next message
// meanwhile. Last-block padding words go in one per cycle while the queue is not full.
// depends on sha256_pkg, sha256_in_if, sha256_out_if, sha256_fifo, sha256_front, sha256_back
`include "assert_macros.svh"
module sha256_hash_top import sha256_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha256_in_if.sink    msg_i,
  sha256_out_if.source dig_o
);

  logic      push, full, pop, empty;
  sha_word_t push_data, pop_data;

  // padding and length front end
  sha256_front u_front (
    .clk_i, .rst_ni, .msg_i,
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  // block word queue
  sha256_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .pop_data_o(pop_data), .empty_o(empty)
  );

  // compression and digest output
  sha256_back u_back (
    .clk_i, .rst_ni,
    .pop_o(pop), .pop_data_i(pop_data), .empty_i(empty), .dig_o
  );

  `ASSERT_NEVER(a_no_overflow, push && full)
  `ASSERT_NEVER(a_no_underflow, pop && empty)
  `ASSERT_ON(a_last_index, dig_o.valid && dig_o.last_digest |-> dig_o.word_index == 3'd7)

endmodule

// ===== tb/sv/sha256_tb_if.sv =====
// checker types: the expected digest transfer record
// channel interfaces come from the rtl files sha256_in_if and sha256_out_if
// depends on nothing
package sha256_tb_types;
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_digest;
  } digest_xfer_t;
endpackage

// ===== tb/sv/sha256_checker.sv =====
// digest checker: watches both channels, hashes accepted message words, compares digests
// depends on sha256_pkg, sha256_tb_types, sha256_in_if, sha256_out_if
module sha256_checker import sha256_pkg::*; import sha256_tb_types::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha256_in_if       msg_if,
  sha256_out_if      dig_if,
  output int         fail_count_o,
  output int         pending_o,
  output int         digests_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]  run_hash [8];
  logic [31:0]  blk [16];
  logic [3:0]   slot;
  logic [63:0]  msg_bits;
  digest_xfer_t digest_fifo [$];

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of the collected block into the running hash
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++) w[t] = blk[t];
    for (int t = 16; t < 64; t++) begin
      w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    end
    for (int i = 0; i < 8; i++) v[i] = run_hash[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) run_hash[i] += v[i];
  endtask

  task automatic append_word(logic [31:0] w);
    blk[slot] = w;
    slot = slot + 4'd1;
    if (slot == 4'd0) compress();
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) run_hash[i] = InitHash[i];
    slot = '0;
    msg_bits = '0;
  endtask

  // absorb one message word, finishing with padding and digest on the last one
  task automatic absorb_word(logic [31:0] data, logic [2:0] nb, logic fin);
    logic [31:0] keep;
    digest_xfer_t d;
    if (!fin) begin
      msg_bits += 64'd32;
      append_word(data);
      return;
    end
    if (nb > 3'd4) nb = 3'd4;
    msg_bits += 64'(nb) * 64'd8;
    if (nb == 3'd4) begin
      append_word(data);
      append_word(PadWord);
    end else begin
      keep = (nb == 3'd0) ? 32'h0 : (32'hffffffff << (8 * (4 - nb)));
      append_word((data & keep) | (32'h80 << (8 * (3 - nb))));
    end
    while (slot != 4'd14) append_word(32'h0);
    append_word(msg_bits[63:32]);
    append_word(msg_bits[31:0]);
    for (int i = 0; i < 8; i++) begin
      d.digest_word = run_hash[i];
      d.word_index  = 3'(i);
      d.last_digest = (i == 7);
      digest_fifo.push_back(d);
    end
    restart_message();
  endtask

  // sample transfers on both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    digest_xfer_t exp_d;
    if (!rst_ni) begin
      restart_message();
      digest_fifo.delete();
      fail_count_o   <= 0;
      digests_seen_o <= 0;
    end else begin
      if (dig_if.valid && dig_if.ready) begin
        if (digest_fifo.size() == 0) begin
          $display("%0t: unexpected digest transfer %h idx %0d", $time,
                   dig_if.digest_word, dig_if.word_index);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_d = digest_fifo.pop_front();
          if (exp_d != {dig_if.digest_word, dig_if.word_index, dig_if.last_digest}) begin
            $display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                     exp_d.digest_word, exp_d.word_index, exp_d.last_digest,
                     dig_if.digest_word, dig_if.word_index, dig_if.last_digest);
            fail_count_o <= fail_count_o + 1;
          end
        end
        if (dig_if.last_digest) digests_seen_o <= digests_seen_o + 1;
      end
      if (msg_if.valid && msg_if.ready)
        absorb_word(msg_if.message_word, msg_if.valid_bytes, msg_if.last_word);
    end
  end

  assign pending_o = digest_fifo.size();

  // words still waiting at the end count as failures in the top
endmodule

// ===== tb/sv/testbench.sv =====
// top: drives random and directed messages into sha256_hash_top and gives the verdict
// depends on sha256_pkg, sha256_in_if, sha256_out_if, sha256_checker, sha256_hash_top
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, digests_seen;
  int   idle_cycles = 0;
  int   words_sent = 0;
  int   burst_left = 0;
  int   messages = 0;

  sha256_in_if  msg_ch();
  sha256_out_if dig_ch();

  sha256_hash_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_ch.sink),
    .dig_o  (dig_ch.source)
  );

  sha256_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .msg_if         (msg_ch),
    .dig_if         (dig_ch),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .digests_seen_o (digests_seen)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // receiver stall pattern: calm stretches, then randomly choppy stretches
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      dig_ch.ready <= 1'b0;
    end else if (($time / 4000) % 3 == 0) begin
      dig_ch.ready <= 1'b1;
    end else begin
      dig_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchdogLimit) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // send one word and wait for its transfer; gaps come between bursts
  task automatic send_word(logic [31:0] data, logic [2:0] nb, logic fin);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        msg_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    msg_ch.valid        <= 1'b1;
    msg_ch.message_word <= data;
    msg_ch.valid_bytes  <= nb;
    msg_ch.last_word    <= fin;
    @(posedge clk_i);
    while (!msg_ch.ready) @(posedge clk_i);
    words_sent++;
    if (fin) messages++;
  endtask

  // a message of body_words full words and a closing word with nb bytes
  task automatic send_message(int body_words, logic [2:0] nb);
    for (int i = 0; i < body_words; i++)
      send_word($urandom(), 3'($urandom_range(0, 7)), 1'b0);
    send_word($urandom(), nb, 1'b1);
  endtask

  initial begin
    int body;
    msg_ch.valid        <= 1'b0;
    msg_ch.message_word <= '0;
    msg_ch.valid_bytes  <= '0;
    msg_ch.last_word    <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    // directed: empty message, every tail length, block-end padding, extremes
    send_word(32'h0000_0000, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word(32'hffff_ffff, 3'd2, 1'b1);
    send_word(32'h6162_6300, 3'd3, 1'b1);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    send_word(32'h0000_0000, 3'd7, 1'b1);
    send_word(32'ha5a5_a5a5, 3'd5, 1'b1);
    send_message(13, 3'd3);
    send_message(13, 3'd4);
    // hold off until all digests are back
    msg_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    send_message(15, 3'd4);
    // random: mostly short messages, a few spanning several blocks
    while (words_sent < 430) begin
      body = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48) : $urandom_range(0, 18);
      send_message(body, 3'($urandom_range(0, 7)));
    end
    msg_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("sent %0d words in %0d messages, %0d digests checked",
             words_sent, messages, digests_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/sha256_pkg.sv
rtl/core/sha256_in_if.sv
rtl/core/sha256_out_if.sv
rtl/core/sha256_fifo.sv
rtl/core/sha256_front.sv
rtl/core/sha256_back.sv
rtl/core/sha256_hash_top.sv
tb/sv/sha256_tb_if.sv
tb/sv/sha256_checker.sv
tb/sv/testbench.sv
